[hdl/hgbs_pkg.sv]
// ----------------------------------------------------------------------------
// hgbs_pkg: shared types and constants of the height grid sampler
// Request and response payloads, configuration fields, register indexes and
// the command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package hgbs_pkg;

    // Configuration port address width and register indexes (word addresses).
    localparam int CFG_ADDR_W = 5;

    localparam logic [2:0] REG_GRID_MAX_X  = 3'd0;
    localparam logic [2:0] REG_GRID_MAX_Z  = 3'd1;
    localparam logic [2:0] REG_ORIGIN_X    = 3'd2;
    localparam logic [2:0] REG_ORIGIN_Z    = 3'd3;
    localparam logic [2:0] REG_INV_SPACING = 3'd4;

    // Operation codes carried in the kind field.
    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_SET    = 2'd1;
    localparam logic [1:0] KIND_ADD    = 2'd2;

    // One request.
    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_z;
        logic [15:0]        cell_index;
        logic signed [15:0] height_value;
    } req_t;

    // One response.
    typedef struct packed {
        logic signed [15:0] sampled_height;
        logic               bad_index;
    } rsp_t;

    // Configuration register contents.
    typedef struct packed {
        logic [7:0]         grid_max_x;
        logic [7:0]         grid_max_z;
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_z;
        logic [23:0]        inv_spacing;
    } cfg_t;

    // Source of the height store address.
    typedef enum logic [1:0] {
        ADDR_CLEAR  = 2'd0,
        ADDR_CORNER = 2'd1,
        ADDR_INDEX  = 2'd2
    } addr_sel_t;

    // Neighbor cell read during a sample: A (x0,z0), B (x1,z0), C (x0,z1), D (x1,z1).
    typedef enum logic [1:0] {
        CORNER_A = 2'd0,
        CORNER_B = 2'd1,
        CORNER_C = 2'd2,
        CORNER_D = 2'd3
    } corner_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      capture;
        logic      mul_en;
        logic      mul_z;
        logic      crd_x;
        logic      crd_z;
        corner_t   rd_corner;
        addr_sel_t addr_sel;
        logic      cap_a;
        logic      cap_b;
        logic      cap_c;
        logic      blend_r;
        logic      blend_v;
        logic      clear_step;
        logic      write_set;
        logic      write_add;
        logic      out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic out_free;
    } sts_t;

endpackage

[hdl/heightgrid_bilinear_sampler_unit.sv]
// ----------------------------------------------------------------------------
// heightgrid_bilinear_sampler_unit: height grid with bilinear sampling
// Stores a grid of signed heights; samples it bilinearly at a world position,
// sets one height or adds a saturating delta to one height.
// ----------------------------------------------------------------------------
//
//   Channel    Handshake                    Payload
//   request    req_valid / req_stall        req (kind, pos_x, pos_z, cell_index,
//                                           height_value)
//   response   rsp_valid / rsp_stall        rsp (sampled_height, bad_index)
//   config     psel, penable, pwrite, pready paddr, pwdata, prdata
//
// A sample runs from acceptance to the response register through the two
// passes through the shared position multiplier and the four reads of the
// single-port height store. A set writes the store, an add reads and then
// writes the same store port, and an unused kind goes straight to the
// response step. The next request is accepted once that step has loaded it.
// After reset the store is cleared one entry a cycle while req_stall stays
// high; configuration writes are taken throughout.
// A new request is accepted while the previous response waits in the
// response register; a request only waits for it at its own last step.
module heightgrid_bilinear_sampler_unit
    import hgbs_pkg::*;
#(
    parameter int STORE_DEPTH = 65536
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  req_t                  req,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output rsp_t                  rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    // Configuration registers.
    hgbs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencer.
    hgbs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .kind      (req.kind),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Arithmetic, height store and response register.
    hgbs_dpath #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

[hdl/hgbs_ram.sv]
// ----------------------------------------------------------------------------
// hgbs_ram: generic single-port RAM
// One read or write per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module hgbs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[hdl/hgbs_regs.sv]
// ----------------------------------------------------------------------------
// hgbs_regs: configuration registers
// APB-style register file holding grid size, origin and reciprocal spacing.
// ----------------------------------------------------------------------------
module hgbs_regs
    import hgbs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign cfg    = cfg_reg;

    // Register write decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (paddr[4:2])
                REG_GRID_MAX_X:  cfg_next.grid_max_x  = pwdata[7:0];
                REG_GRID_MAX_Z:  cfg_next.grid_max_z  = pwdata[7:0];
                REG_ORIGIN_X:    cfg_next.origin_x    = pwdata[15:0];
                REG_ORIGIN_Z:    cfg_next.origin_z    = pwdata[15:0];
                REG_INV_SPACING: cfg_next.inv_spacing = pwdata[23:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grid_max_x  <= 8'd255;
            cfg_reg.grid_max_z  <= 8'd255;
            cfg_reg.origin_x    <= 16'sd0;
            cfg_reg.origin_z    <= 16'sd0;
            cfg_reg.inv_spacing <= 24'd65536;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read data multiplexer.
    always_comb
    begin
        case (paddr[4:2])
            REG_GRID_MAX_X:  prdata = {24'd0, cfg_reg.grid_max_x};
            REG_GRID_MAX_Z:  prdata = {24'd0, cfg_reg.grid_max_z};
            REG_ORIGIN_X:    prdata = {{16{cfg_reg.origin_x[15]}}, cfg_reg.origin_x};
            REG_ORIGIN_Z:    prdata = {{16{cfg_reg.origin_z[15]}}, cfg_reg.origin_z};
            REG_INV_SPACING: prdata = {8'd0, cfg_reg.inv_spacing};
            default:         prdata = 32'd0;
        endcase
    end

endmodule

[hdl/hgbs_ctrl.sv]
// ----------------------------------------------------------------------------
// hgbs_ctrl: sequencing state machine
// Runs the clearing pass after reset and steps each request through the
// datapath: scaling, four neighbor reads and blending, or a set or add.
// ----------------------------------------------------------------------------
module hgbs_ctrl
    import hgbs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  logic [1:0] kind,
    input  sts_t       sts,
    output cmd_t       cmd
);

    typedef enum logic [14:0] {
        ST_CLEAR    = 15'b000000000000001,
        ST_IDLE     = 15'b000000000000010,
        ST_MUL_X    = 15'b000000000000100,
        ST_MUL_Z    = 15'b000000000001000,
        ST_CRD_Z    = 15'b000000000010000,
        ST_RD_A     = 15'b000000000100000,
        ST_RD_B     = 15'b000000001000000,
        ST_RD_C     = 15'b000000010000000,
        ST_RD_D     = 15'b000000100000000,
        ST_BLEND_R  = 15'b000001000000000,
        ST_BLEND_V  = 15'b000010000000000,
        ST_WRITE    = 15'b000100000000000,
        ST_READ_OLD = 15'b001000000000000,
        ST_ADD      = 15'b010000000000000,
        ST_RESP     = 15'b100000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign req_stall = (state_reg != ST_IDLE);

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                cmd.addr_sel   = ADDR_CLEAR;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cmd.capture = req_valid;
                if (req_valid)
                begin
                    case (kind)
                        KIND_SAMPLE: state_next = ST_MUL_X;
                        KIND_SET:    state_next = ST_WRITE;
                        KIND_ADD:    state_next = ST_READ_OLD;
                        default:     state_next = ST_RESP;
                    endcase
                end
            end
            ST_MUL_X:
            begin
                cmd.mul_en = 1'b1;
                state_next = ST_MUL_Z;
            end
            ST_MUL_Z:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_z  = 1'b1;
                cmd.crd_x  = 1'b1;
                state_next = ST_CRD_Z;
            end
            ST_CRD_Z:
            begin
                cmd.crd_z  = 1'b1;
                state_next = ST_RD_A;
            end
            ST_RD_A:
            begin
                cmd.addr_sel  = ADDR_CORNER;
                cmd.rd_corner = CORNER_A;
                state_next    = ST_RD_B;
            end
            ST_RD_B:
            begin
                cmd.addr_sel  = ADDR_CORNER;
                cmd.rd_corner = CORNER_B;
                cmd.cap_a     = 1'b1;
                state_next    = ST_RD_C;
            end
            ST_RD_C:
            begin
                cmd.addr_sel  = ADDR_CORNER;
                cmd.rd_corner = CORNER_C;
                cmd.cap_b     = 1'b1;
                state_next    = ST_RD_D;
            end
            ST_RD_D:
            begin
                cmd.addr_sel  = ADDR_CORNER;
                cmd.rd_corner = CORNER_D;
                cmd.cap_c     = 1'b1;
                state_next    = ST_BLEND_R;
            end
            ST_BLEND_R:
            begin
                cmd.blend_r = 1'b1;
                state_next  = ST_BLEND_V;
            end
            ST_BLEND_V:
            begin
                cmd.blend_v = 1'b1;
                state_next  = ST_RESP;
            end
            ST_WRITE:
            begin
                cmd.addr_sel  = ADDR_INDEX;
                cmd.write_set = 1'b1;
                state_next    = ST_RESP;
            end
            ST_READ_OLD:
            begin
                cmd.addr_sel = ADDR_INDEX;
                state_next   = ST_ADD;
            end
            ST_ADD:
            begin
                cmd.addr_sel  = ADDR_INDEX;
                cmd.write_add = 1'b1;
                state_next    = ST_RESP;
            end
            ST_RESP:
            begin
                cmd.out_load = sts.out_free;
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[hdl/hgbs_dpath.sv]
// ----------------------------------------------------------------------------
// hgbs_dpath: sampler datapath
// Position scaling, cell clamping, neighbor addressing, bilinear blend,
// set and saturating add, the height store and the response register.
// ----------------------------------------------------------------------------
module hgbs_dpath
    import hgbs_pkg::*;
#(
    parameter int STORE_DEPTH = 65536
) (
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  req_t req,
    input  cmd_t cmd,
    output sts_t sts,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int         AW      = $clog2(STORE_DEPTH);
    localparam logic [20:0] DEPTH_W = 21'(STORE_DEPTH);

    // Clamp a cell coordinate and its successor to 0 .. hi; returns {c1, c0}.
    function automatic logic [15:0] clamp_pair(input logic signed [33:0] c,
                                               input logic [7:0] hi);
        logic [15:0] pair;
        if (c[33])
        begin
            pair = 16'd0;
        end
        else if (c >= $signed({26'd0, hi}))
        begin
            pair = {hi, hi};
        end
        else
        begin
            pair = {c[7:0] + 8'd1, c[7:0]};
        end
        return pair;
    endfunction

    req_t               req_reg;
    logic signed [56:0] prod_reg;
    logic [7:0]         x0_reg;
    logic [7:0]         x1_reg;
    logic [7:0]         z0_reg;
    logic [7:0]         z1_reg;
    logic [7:0]         fx_reg;
    logic [7:0]         fz_reg;
    logic signed [15:0] a_reg;
    logic signed [15:0] b_reg;
    logic signed [15:0] c_reg;
    logic               oor_reg;
    logic signed [25:0] r0_reg;
    logic signed [25:0] r1_reg;
    logic signed [15:0] res_reg;
    logic               bad_reg;
    logic [AW-1:0]      clr_cnt_reg;
    logic               rsp_valid_reg;
    rsp_t               rsp_reg;

    logic signed [31:0] mul_pos;
    logic signed [24:0] inv_s;
    logic signed [56:0] prod_next;
    logic signed [15:0] origin_sel;
    logic [7:0]         hi_sel;
    logic signed [41:0] coord;
    logic [15:0]        clamp_out;
    logic [7:0]         cx;
    logic [7:0]         cz;
    logic [8:0]         stride;
    logic [8:0]         rows;
    logic [16:0]        lin;
    logic               corner_oor;
    logic [17:0]        cells;
    logic               idx_bad;
    logic [AW-1:0]      ram_addr;
    logic               ram_we;
    logic [15:0]        ram_wdata;
    logic [15:0]        ram_rdata;
    logic signed [15:0] rd_val;
    logic signed [16:0] diff0;
    logic signed [16:0] diff1;
    logic signed [8:0]  fx_s;
    logic signed [8:0]  fz_s;
    logic signed [25:0] r0_next;
    logic signed [25:0] r1_next;
    logic signed [26:0] dr;
    logic signed [36:0] v_rnd;
    logic signed [16:0] sum;
    logic signed [15:0] sat;
    logic               out_free;

    // Position scaling: one signed 32 x 25 multiply, shared by both axes.
    assign mul_pos   = cmd.mul_z ? req_reg.pos_z : req_reg.pos_x;
    assign inv_s     = $signed({1'b0, cfg.inv_spacing});
    assign prod_next = mul_pos * inv_s;

    // Grid coordinate in Q.8, then the clamped neighbor cells of that axis.
    assign origin_sel = cmd.crd_z ? cfg.origin_z : cfg.origin_x;
    assign hi_sel     = cmd.crd_z ? cfg.grid_max_z : cfg.grid_max_x;
    assign coord      = $signed(prod_reg[56:16]) - $signed({origin_sel, 8'd0});
    assign clamp_out  = clamp_pair($signed(coord[41:8]), hi_sel);

    // Linear address of the neighbor being read.
    always_comb
    begin
        case (cmd.rd_corner)
            CORNER_A:
            begin
                cx = x0_reg;
                cz = z0_reg;
            end
            CORNER_B:
            begin
                cx = x1_reg;
                cz = z0_reg;
            end
            CORNER_C:
            begin
                cx = x0_reg;
                cz = z1_reg;
            end
            CORNER_D:
            begin
                cx = x1_reg;
                cz = z1_reg;
            end
            default:
            begin
                cx = x0_reg;
                cz = z0_reg;
            end
        endcase
    end

    assign stride     = {1'b0, cfg.grid_max_x} + 9'd1;
    assign rows       = {1'b0, cfg.grid_max_z} + 9'd1;
    assign lin        = 17'(stride) * 17'(cz) + 17'(cx);
    assign corner_oor = ({4'd0, lin} >= DEPTH_W);

    // Index check for set and add.
    assign cells   = 18'(stride) * 18'(rows);
    assign idx_bad = ({2'd0, req_reg.cell_index} >= cells) ||
                     ({5'd0, req_reg.cell_index} >= DEPTH_W);

    // Read data; a cell beyond the store reads as zero.
    assign rd_val = oor_reg ? 16'sd0 : $signed(ram_rdata);

    // Saturating add of the delta to the stored height.
    assign sum = rd_val + req_reg.height_value;
    always_comb
    begin
        if (!sum[16] && sum[15])
        begin
            sat = 16'sh7FFF;
        end
        else if (sum[16] && !sum[15])
        begin
            sat = -16'sh8000;
        end
        else
        begin
            sat = sum[15:0];
        end
    end

    // Height store address and write data.
    always_comb
    begin
        case (cmd.addr_sel)
            ADDR_CLEAR:  ram_addr = clr_cnt_reg;
            ADDR_CORNER: ram_addr = AW'(lin);
            ADDR_INDEX:  ram_addr = AW'(req_reg.cell_index);
            default:     ram_addr = clr_cnt_reg;
        endcase
    end

    assign ram_we = cmd.clear_step | ((cmd.write_set | cmd.write_add) & ~idx_bad);

    always_comb
    begin
        if (cmd.write_set)
        begin
            ram_wdata = req_reg.height_value;
        end
        else if (cmd.write_add)
        begin
            ram_wdata = sat;
        end
        else
        begin
            ram_wdata = 16'd0;
        end
    end

    hgbs_ram #(
        .WIDTH (16),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Row blends: r = a*256 + fx*(b - a), both rows in parallel.
    assign fx_s    = $signed({1'b0, fx_reg});
    assign fz_s    = $signed({1'b0, fz_reg});
    assign diff0   = b_reg - a_reg;
    assign diff1   = rd_val - c_reg;
    assign r0_next = $signed({{2{a_reg[15]}}, a_reg, 8'd0}) + diff0 * fx_s;
    assign r1_next = $signed({{2{c_reg[15]}}, c_reg, 8'd0}) + diff1 * fx_s;

    // Column blend with rounding to nearest, ties upward.
    assign dr    = r1_reg - r0_reg;
    assign v_rnd = $signed({{3{r0_reg[25]}}, r0_reg, 8'd0}) + dr * fz_s + 37'sd32768;

    // Response register.
    assign out_free       = ~rsp_valid_reg | ~rsp_stall;
    assign sts.out_free   = out_free;
    assign sts.clear_last = (clr_cnt_reg == AW'(STORE_DEPTH - 1));
    assign rsp_valid      = rsp_valid_reg;
    assign rsp            = rsp_reg;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cmd.out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        oor_reg <= (cmd.addr_sel == ADDR_CORNER) ? corner_oor : 1'b0;
        if (cmd.capture)
        begin
            req_reg <= req;
            res_reg <= 16'sd0;
            bad_reg <= 1'b0;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.crd_x)
        begin
            x0_reg <= clamp_out[7:0];
            x1_reg <= clamp_out[15:8];
            fx_reg <= coord[7:0];
        end
        if (cmd.crd_z)
        begin
            z0_reg <= clamp_out[7:0];
            z1_reg <= clamp_out[15:8];
            fz_reg <= coord[7:0];
        end
        if (cmd.cap_a)
        begin
            a_reg <= rd_val;
        end
        if (cmd.cap_b)
        begin
            b_reg <= rd_val;
        end
        if (cmd.cap_c)
        begin
            c_reg <= rd_val;
        end
        if (cmd.blend_r)
        begin
            r0_reg <= r0_next;
            r1_reg <= r1_next;
        end
        if (cmd.blend_v)
        begin
            res_reg <= v_rnd[31:16];
        end
        if (cmd.write_set)
        begin
            res_reg <= idx_bad ? 16'sd0 : req_reg.height_value;
            bad_reg <= idx_bad;
        end
        if (cmd.write_add)
        begin
            res_reg <= idx_bad ? 16'sd0 : sat;
            bad_reg <= idx_bad;
        end
        if (cmd.out_load)
        begin
            rsp_reg.sampled_height <= res_reg;
            rsp_reg.bad_index      <= bad_reg;
        end
    end

endmodule

[tb/hgbs_response_checker.sv]
// ----------------------------------------------------------------------------
// hgbs_response_checker: response predictor and scoreboard for the sampler
// Watches the request, response and configuration channels of the height
// grid sampler, keeps its own copy of the height grid and the registers,
// works out the response of every accepted request and compares each
// accepted response against the oldest one still outstanding.
// ----------------------------------------------------------------------------
module hgbs_response_checker
    import hgbs_pkg::*;
#(
    parameter int STORE_DEPTH = 65536
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    input  logic                  req_stall,
    input  req_t                  req,
    input  logic                  rsp_valid,
    input  logic                  rsp_stall,
    input  rsp_t                  rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output int                    mismatches,
    output int                    pending
);

    // Shadow copy of the height grid and of the configuration registers.
    logic signed [15:0] height_mem [STORE_DEPTH];
    cfg_t               cfg_shadow;

    // Responses predicted for accepted requests, oldest first.
    rsp_t               expected_rsp_q [$];

    // Height at a clamped cell; cells past the end of the store read as zero.
    function automatic longint fetch_height(input longint x, input longint z);
        longint lin_idx;
        lin_idx = x + (longint'(cfg_shadow.grid_max_x) + 1) * z;
        if (lin_idx >= STORE_DEPTH)
            return 0;
        return longint'(height_mem[lin_idx]);
    endfunction

    function automatic longint clamp_axis(input longint c, input longint hi);
        if (c < 0)
            return 0;
        if (c > hi)
            return hi;
        return c;
    endfunction

    // Bilinear blend of the four neighbors around a world position.
    function automatic longint blend_sample(input logic signed [31:0] px,
                                            input logic signed [31:0] pz);
        longint inv, cx, cz, ix, iz, fx, fz;
        longint x0, x1, z0, z1, hi_x, hi_z;
        longint a, b, c, d, r0, r1, v;
        inv  = longint'(cfg_shadow.inv_spacing);
        hi_x = longint'(cfg_shadow.grid_max_x);
        hi_z = longint'(cfg_shadow.grid_max_z);
        // Scale to Q.8 grid units, then remove the grid offset.
        cx = ((longint'(px) * inv) >>> 16) - longint'(cfg_shadow.origin_x) * 256;
        cz = ((longint'(pz) * inv) >>> 16) - longint'(cfg_shadow.origin_z) * 256;
        ix = cx >>> 8;
        iz = cz >>> 8;
        fx = cx & 255;
        fz = cz & 255;
        x0 = clamp_axis(ix, hi_x);
        x1 = clamp_axis(ix + 1, hi_x);
        z0 = clamp_axis(iz, hi_z);
        z1 = clamp_axis(iz + 1, hi_z);
        a  = fetch_height(x0, z0);
        b  = fetch_height(x1, z0);
        c  = fetch_height(x0, z1);
        d  = fetch_height(x1, z1);
        r0 = a * 256 + fx * (b - a);
        r1 = c * 256 + fx * (d - c);
        v  = r0 * 256 + fz * (r1 - r0);
        // Round to nearest with ties going up.
        return (v + 32768) >>> 16;
    endfunction

    // Expected response of one request; set and add update the shadow grid.
    function automatic rsp_t predict_response(input req_t r);
        rsp_t   e;
        longint cells, idx, h;
        e.sampled_height = '0;
        e.bad_index      = 1'b0;
        case (r.kind)
            KIND_SAMPLE:
            begin
                h = blend_sample(r.pos_x, r.pos_z);
                e.sampled_height = h[15:0];
            end
            KIND_SET, KIND_ADD:
            begin
                cells = (longint'(cfg_shadow.grid_max_x) + 1) *
                        (longint'(cfg_shadow.grid_max_z) + 1);
                idx   = longint'(r.cell_index);
                if (idx >= cells || idx >= STORE_DEPTH)
                begin
                    e.bad_index = 1'b1;
                end
                else
                begin
                    h = longint'(r.height_value);
                    if (r.kind == KIND_ADD)
                    begin
                        h = h + longint'(height_mem[idx]);
                        if (h > 32767)
                            h = 32767;
                        if (h < -32768)
                            h = -32768;
                    end
                    height_mem[idx] = h[15:0];
                    e.sampled_height = h[15:0];
                end
            end
            default:
            begin
            end
        endcase
        return e;
    endfunction

    // Track register writes, check responses, then predict new requests.
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t oldest;
        if (!rst_n)
        begin
            foreach (height_mem[i])
                height_mem[i] = 16'sd0;
            cfg_shadow.grid_max_x  = 8'd255;
            cfg_shadow.grid_max_z  = 8'd255;
            cfg_shadow.origin_x    = 16'sd0;
            cfg_shadow.origin_z    = 16'sd0;
            cfg_shadow.inv_spacing = 24'd65536;
            expected_rsp_q.delete();
            mismatches = 0;
            pending    = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[CFG_ADDR_W-1:2])
                    REG_GRID_MAX_X:  cfg_shadow.grid_max_x  = pwdata[7:0];
                    REG_GRID_MAX_Z:  cfg_shadow.grid_max_z  = pwdata[7:0];
                    REG_ORIGIN_X:    cfg_shadow.origin_x    = pwdata[15:0];
                    REG_ORIGIN_Z:    cfg_shadow.origin_z    = pwdata[15:0];
                    REG_INV_SPACING: cfg_shadow.inv_spacing = pwdata[23:0];
                    default:
                    begin
                    end
                endcase
            end

            // A response belongs to an older request, so it is checked first.
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    $error("unexpected response: sampled_height %0d bad_index %0d",
                           rsp.sampled_height, rsp.bad_index);
                    mismatches++;
                end
                else
                begin
                    oldest = expected_rsp_q.pop_front();
                    if (rsp.sampled_height !== oldest.sampled_height)
                    begin
                        $error("sampled_height mismatch: expected %0d, actual %0d",
                               oldest.sampled_height, rsp.sampled_height);
                        mismatches++;
                    end
                    if (rsp.bad_index !== oldest.bad_index)
                    begin
                        $error("bad_index mismatch: expected %0d, actual %0d",
                               oldest.bad_index, rsp.bad_index);
                        mismatches++;
                    end
                end
            end

            if (req_valid && !req_stall)
                expected_rsp_q.push_back(predict_response(req));

            pending = expected_rsp_q.size();
        end
    end

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the height grid sampler
// Drives a short directed sequence and then randomized phases of sample,
// set and add requests under several register settings and idle/stall mixes.
// A separate checker predicts and compares every response.
// ----------------------------------------------------------------------------
module testbench;
    import hgbs_pkg::*;

    localparam int         STORE_DEPTH   = 65536;
    localparam int         IDLE_LIMIT    = 300000;
    localparam int         SETTLE_CYCLES = 16;
    localparam int         PHASES        = 12;
    localparam int         PHASE_ITEMS   = 145;
    localparam int         RECENT_DEPTH  = 16;
    localparam logic [1:0] KIND_UNUSED   = 2'd3;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    req_t                  req       = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    rsp_t                  rsp;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr     = '0;
    logic [31:0]           pwdata    = '0;
    logic [31:0]           prdata;
    logic                  pready;

    int mismatches;
    int pending;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int quiet_cycles  = 0;
    int sample_count  = 0;
    int set_count     = 0;
    int add_count     = 0;
    int unused_count  = 0;

    // Registers as last written, and cells recently written, for aiming samples.
    cfg_t        cur_cfg;
    logic [15:0] recent_cells [$];

    heightgrid_bilinear_sampler_unit #(
        .STORE_DEPTH(STORE_DEPTH)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    hgbs_response_checker #(
        .STORE_DEPTH(STORE_DEPTH)
    ) i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .pready    (pready),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .mismatches(mismatches),
        .pending   (pending)
    );

    // Clock with a period of four time units.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Random response back-pressure.
    always @(negedge clk)
    begin
        rsp_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Watchdog: too long without any request or response moving.
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL heightgrid_bilinear_sampler_unit");
            $finish;
        end
    end

    function automatic req_t make_req(input logic [1:0]         k,
                                      input logic signed [31:0] px,
                                      input logic signed [31:0] pz,
                                      input logic [15:0]        idx,
                                      input logic signed [15:0] h);
        req_t r;
        r.kind         = k;
        r.pos_x        = px;
        r.pos_z        = pz;
        r.cell_index   = idx;
        r.height_value = h;
        return r;
    endfunction

    function automatic cfg_t make_cfg(input logic [7:0]         gx,
                                      input logic [7:0]         gz,
                                      input logic signed [15:0] ox,
                                      input logic signed [15:0] oz,
                                      input logic [23:0]        inv);
        cfg_t c;
        c.grid_max_x  = gx;
        c.grid_max_z  = gz;
        c.origin_x    = ox;
        c.origin_z    = oz;
        c.inv_spacing = inv;
        return c;
    endfunction

    // Register settings per phase: edge grids, extreme origins and spacings.
    function automatic cfg_t cfg_setting(input int n);
        case (n)
            0:       return make_cfg(8'd255, 8'd255, 16'sd0, 16'sd0, 24'd65536);
            1:       return make_cfg(8'd7, 8'd7, 16'sd0, 16'sd0, 24'd65536);
            2:       return make_cfg(8'd15, 8'd3, -16'sd5, 16'sd2, 24'd32768);
            3:       return make_cfg(8'd0, 8'd0, 16'sd0, 16'sd0, 24'd65536);
            4:       return make_cfg(8'd255, 8'd0, 16'sd32767, -16'sd32768, 24'd1);
            5:       return make_cfg(8'd0, 8'd255, -16'sd32768, 16'sd32767, 24'hFFFFFF);
            6:       return make_cfg(8'd31, 8'd31, 16'sd100, -16'sd100, 24'd200000);
            7:       return make_cfg(8'd3, 8'd5, 16'sd2, -16'sd3, 24'd0);
            8:       return make_cfg(8'd127, 8'd63, -16'sd1, 16'sd1, 24'd196608);
            default: return make_cfg(8'($urandom_range(0, 255)),
                                     8'($urandom_range(0, 255)),
                                     16'($urandom_range(0, 65535)),
                                     16'($urandom_range(0, 65535)),
                                     24'($urandom_range(0, 24'hFFFFFF)));
        endcase
    endfunction

    // World coordinate that lands at a chosen cell plus a random fraction.
    function automatic logic signed [31:0] aim_axis(input int cell_pos,
                                                    input logic signed [15:0] org);
        longint q, p;
        q = longint'(cell_pos) * 256 + longint'($urandom_range(0, 255)) +
            longint'(org) * 256;
        if (cur_cfg.inv_spacing == 0)
            return $urandom;
        p = (q * 65536) / longint'(cur_cfg.inv_spacing);
        if (p > 64'sd2147483647)
            p = 64'sd2147483647;
        if (p < -64'sd2147483648)
            p = -64'sd2147483648;
        return p[31:0];
    endfunction

    // Height or delta, weighted toward the saturation limits and small values.
    function automatic logic signed [15:0] pick_height();
        int s;
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:
            begin
                s = $urandom_range(0, 16);
                return 16'(s - 8);
            end
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Mostly well-formed traffic inside the grid, with some noise around it.
    function automatic req_t random_request();
        req_t        r;
        int          roll, x, z, stride;
        logic [15:0] pick_cell;
        r = make_req(KIND_SAMPLE, $urandom, $urandom, 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)));
        stride = int'(cur_cfg.grid_max_x) + 1;
        roll   = $urandom_range(0, 99);
        if (roll < 40)
        begin
            // Sample aimed at a recently written cell or at a random cell, one past each grid edge included.
            if (recent_cells.size() != 0 && $urandom_range(0, 2) != 0)
            begin
                pick_cell = recent_cells[$urandom_range(0, recent_cells.size() - 1)];
                x = int'(pick_cell) % stride;
                z = int'(pick_cell) / stride;
            end
            else
            begin
                x = $urandom_range(0, cur_cfg.grid_max_x + 2) - 1;
                z = $urandom_range(0, cur_cfg.grid_max_z + 2) - 1;
            end
            r.pos_x = aim_axis(x, cur_cfg.origin_x);
            r.pos_z = aim_axis(z, cur_cfg.origin_z);
        end
        else if (roll < 48)
        begin
            // Sample at a fully random position.
        end
        else if (roll < 94)
        begin
            x         = $urandom_range(0, cur_cfg.grid_max_x);
            z         = $urandom_range(0, cur_cfg.grid_max_z);
            pick_cell = 16'(x + stride * z);
            r.kind         = (roll < 70) ? KIND_SET : KIND_ADD;
            r.cell_index   = pick_cell;
            r.height_value = pick_height();
            recent_cells.push_back(pick_cell);
            if (recent_cells.size() > RECENT_DEPTH)
                void'(recent_cells.pop_front());
        end
        else if (roll < 98)
        begin
            // Set or add at any index, often outside a small grid.
            r.kind = ($urandom_range(0, 1) != 0) ? KIND_SET : KIND_ADD;
        end
        else
        begin
            r.kind = KIND_UNUSED;
        end
        return r;
    endfunction

    // Present one request, with random idle cycles before it, until accepted.
    task automatic send_request(input req_t item);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        case (item.kind)
            KIND_SAMPLE: sample_count++;
            KIND_SET:    set_count++;
            KIND_ADD:    add_count++;
            default:     unused_count++;
        endcase
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // One register write: setup cycle, then access cycle until pready.
    task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apply_config(input cfg_t c);
        cur_cfg = c;
        write_register(REG_GRID_MAX_X, {24'd0, c.grid_max_x});
        write_register(REG_GRID_MAX_Z, {24'd0, c.grid_max_z});
        write_register(REG_ORIGIN_X, {{16{c.origin_x[15]}}, c.origin_x});
        write_register(REG_ORIGIN_Z, {{16{c.origin_z[15]}}, c.origin_z});
        write_register(REG_INV_SPACING, {8'd0, c.inv_spacing});
    endtask

    // Stop sending and wait for every outstanding response, then settle.
    task automatic wait_drained();
        req_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    initial
    begin
        int p;
        int n;
        cur_cfg = make_cfg(8'd255, 8'd255, 16'sd0, 16'sd0, 24'd65536);
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed requests on the reset grid, where a position maps to a cell.
        send_request(make_req(KIND_SAMPLE, 32'sd0, 32'sd0, 16'd0, 16'sd0));
        send_request(make_req(KIND_SET, 32'sd0, 32'sd0, 16'd0, 16'sh7FFF));
        send_request(make_req(KIND_SET, 32'sd0, 32'sd0, 16'd1, 16'sh8000));
        send_request(make_req(KIND_SET, 32'sd0, 32'sd0, 16'd256, 16'sd1000));
        send_request(make_req(KIND_SET, 32'sd0, 32'sd0, 16'd257, -16'sd1000));
        send_request(make_req(KIND_SAMPLE, 32'sd128, 32'sd128, 16'd0, 16'sd0));
        send_request(make_req(KIND_SAMPLE, 32'sd64, 32'sd192, 16'd0, 16'sd0));
        send_request(make_req(KIND_ADD, 32'sd0, 32'sd0, 16'd0, 16'sd1));
        send_request(make_req(KIND_ADD, 32'sd0, 32'sd0, 16'd1, -16'sd1));
        send_request(make_req(KIND_ADD, 32'sd0, 32'sd0, 16'd256, 16'sh8000));
        send_request(make_req(KIND_SET, 32'sd0, 32'sd0, 16'hFFFF, 16'sd5));
        send_request(make_req(KIND_SAMPLE, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 16'd0, 16'sd0));
        send_request(make_req(KIND_SAMPLE, 32'sh80000000, 32'sh80000000, 16'd0, 16'sd0));
        send_request(make_req(KIND_SAMPLE, -32'sd1, -32'sd1, 16'd0, 16'sd0));
        send_request(make_req(KIND_SAMPLE, 32'sd255, 32'sd255, 16'd0, 16'sd0));
        send_request(make_req(KIND_UNUSED, -32'sd1, -32'sd1, 16'hFFFF, -16'sd1));
        send_request(make_req(KIND_ADD, 32'sd0, 32'sd0, 16'hFFFF, 16'sh7FFF));
        wait_drained();

        // Shrink the grid to 4 x 4 so that indexes fall outside it.
        write_register(REG_GRID_MAX_X, 32'd3);
        write_register(REG_GRID_MAX_Z, 32'd3);
        cur_cfg.grid_max_x = 8'd3;
        cur_cfg.grid_max_z = 8'd3;
        send_request(make_req(KIND_SET, 32'sd0, 32'sd0, 16'd15, -16'sd7));
        send_request(make_req(KIND_SET, 32'sd0, 32'sd0, 16'd16, 16'sd9));
        send_request(make_req(KIND_ADD, 32'sd0, 32'sd0, 16'hFFFF, 16'sd1));
        send_request(make_req(KIND_SAMPLE, 32'sd896, 32'sd896, 16'd0, 16'sd0));
        send_request(make_req(KIND_SET, -32'sd1, -32'sd1, 16'd0, 16'sd0));
        wait_drained();

        // Random phases, each with its own registers and idle/stall mix.
        for (p = 0; p < PHASES; p++)
        begin
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 47;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 47;
                end
                default:
                begin
                    send_idle_pct = 33;
                    stall_pct     = 33;
                end
            endcase
            apply_config(cfg_setting(p));
            for (n = 0; n < PHASE_ITEMS; n++)
                send_request(random_request());
            wait_drained();
        end

        $display("Checked %0d requests: %0d samples, %0d sets, %0d adds, %0d unused kind.",
                 sample_count + set_count + add_count + unused_count,
                 sample_count, set_count, add_count, unused_count);
        $display("Covered %0d register settings, edge grids included, under four stall mixes.",
                 PHASES + 1);
        if (mismatches == 0)
            $display("PASS heightgrid_bilinear_sampler_unit");
        else
            $display("FAIL heightgrid_bilinear_sampler_unit");
        $finish;
    end

endmodule

[sim.f]
hdl/hgbs_pkg.sv
hdl/hgbs_ram.sv
hdl/hgbs_regs.sv
hdl/hgbs_ctrl.sv
hdl/hgbs_dpath.sv
hdl/heightgrid_bilinear_sampler_unit.sv
tb/hgbs_response_checker.sv
tb/testbench.sv
